[hw/rtl/ctr_pkg.sv]
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and codes of the chunked transfer receiver: the header
// transfer, the reply transfer, the configuration bundle and the field codes.
// ----------------------------------------------------------------------------
package ctr_pkg;

	localparam logic [2:0] PK_START = 3'd0;
	localparam logic [2:0] PK_DATA  = 3'd1;
	localparam logic [2:0] PK_END   = 3'd2;
	localparam logic [2:0] PK_ACK   = 3'd3;
	localparam logic [2:0] PK_ERROR = 3'd4;

	localparam logic [1:0] RK_NONE = 2'd0;
	localparam logic [1:0] RK_ACK  = 2'd1;
	localparam logic [1:0] RK_ERR  = 2'd2;

	localparam logic [1:0] AC_START = 2'd0;
	localparam logic [1:0] AC_DATA  = 2'd1;
	localparam logic [1:0] AC_END   = 2'd2;

	localparam logic [1:0] EC_TOO_LARGE = 2'd0;
	localparam logic [1:0] EC_SEQUENCE  = 2'd1;
	localparam logic [1:0] EC_CHECKSUM  = 2'd2;
	localparam logic [1:0] EC_MALFORMED = 2'd3;

	localparam logic [1:0] OC_CONTINUE = 2'd0;
	localparam logic [1:0] OC_COMPLETE = 2'd1;
	localparam logic [1:0] OC_ABORTED  = 2'd2;

	localparam logic [31:0] MAX_FILE_SIZE_RST = 32'd1048576;
	localparam logic [15:0] MAX_CHUNK_LEN_RST = 16'd1024;

	localparam logic REG_MAX_FILE_SIZE = 1'b0;
	localparam logic REG_MAX_CHUNK_LEN = 1'b1;

	typedef struct packed {
		logic [47:0] source_address;
		logic [2:0]  packet_kind;
		logic [31:0] transfer_tag;
		logic [31:0] seq_number;
		logic [31:0] byte_offset;
		logic [31:0] length_field;
		logic [31:0] header_check;
		logic [15:0] payload_bytes;
		logic [31:0] payload_check;
		logic        payload_matches_store;
		logic [31:0] stored_check;
	} item_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [1:0]  reply_code;
		logic [31:0] reply_tag;
		logic [31:0] reply_seq;
		logic        store_chunk;
		logic [31:0] store_offset;
		logic [1:0]  outcome;
	} result_t;

	typedef struct packed {
		logic [31:0] max_file_size;
		logic [15:0] max_chunk_len;
	} cfg_t;

endpackage

[hw/rtl/ctr_cfg.sv]
// ----------------------------------------------------------------------------
// ctr_cfg
// APB-style register file holding the size limits of the receiver.
// ----------------------------------------------------------------------------
module ctr_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output ctr_pkg::cfg_t cfg
);
	import ctr_pkg::*;

	logic [31:0] max_file_size_q;
	logic [15:0] max_chunk_len_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_file_size_q <= MAX_FILE_SIZE_RST;
			max_chunk_len_q <= MAX_CHUNK_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_FILE_SIZE: max_file_size_q <= pwdata;
				REG_MAX_CHUNK_LEN: max_chunk_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_FILE_SIZE: prdata = max_file_size_q;
			REG_MAX_CHUNK_LEN: prdata = {16'd0, max_chunk_len_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.max_file_size = max_file_size_q;
	assign cfg.max_chunk_len = max_chunk_len_q;

endmodule

[hw/rtl/ctr_core.sv]
// ----------------------------------------------------------------------------
// ctr_core
// Transfer state and the single-pass decision logic: one header in, one
// reply out, state updated on the same edge.
// ----------------------------------------------------------------------------
module ctr_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  ctr_pkg::item_t  item,
	input  ctr_pkg::cfg_t   cfg,
	output ctr_pkg::result_t res
);
	import ctr_pkg::*;

	logic        receiving_q, receiving_d;
	logic [47:0] peer_address_q, peer_address_d;
	logic [31:0] active_tag_q, active_tag_d;
	logic [31:0] expected_size_q, expected_size_d;
	logic [31:0] expected_check_q, expected_check_d;
	logic [31:0] next_seq_q, next_seq_d;
	logic [31:0] bytes_received_q, bytes_received_d;

	logic [31:0] len;
	logic [31:0] off;
	logic        same_peer;
	logic        len_ok;
	logic        dup;
	logic        seq_fault;
	logic        end_fault;

	assign len       = item.length_field;
	assign off       = item.byte_offset;
	assign same_peer = (item.source_address == peer_address_q) &&
		(item.transfer_tag == active_tag_q);
	assign len_ok    = (len <= {16'd0, cfg.max_chunk_len}) &&
		(len <= {16'd0, item.payload_bytes});

	assign dup = (next_seq_q != 32'd0) && (item.seq_number == next_seq_q - 32'd1) &&
		len_ok && (off <= expected_size_q) && (len <= expected_size_q - off) &&
		(off + len == bytes_received_q) &&
		(item.payload_check == item.header_check) &&
		((len == 32'd0) || item.payload_matches_store);

	assign seq_fault = (item.seq_number != next_seq_q) || (off != bytes_received_q) ||
		!len_ok || (len > expected_size_q - bytes_received_q);

	assign end_fault = (item.seq_number != next_seq_q) || (off != bytes_received_q) ||
		(len != expected_size_q) || (bytes_received_q != expected_size_q) ||
		(item.header_check != expected_check_q) ||
		(item.stored_check != expected_check_q);

	always_comb begin
		receiving_d      = receiving_q;
		peer_address_d   = peer_address_q;
		active_tag_d     = active_tag_q;
		expected_size_d  = expected_size_q;
		expected_check_d = expected_check_q;
		next_seq_d       = next_seq_q;
		bytes_received_d = bytes_received_q;
		res              = '0;

		if (!receiving_q) begin
			if (item.packet_kind == PK_START) begin
				peer_address_d   = item.source_address;
				active_tag_d     = item.transfer_tag;
				expected_size_d  = len;
				expected_check_d = item.header_check;
				res.reply_tag    = item.transfer_tag;
				res.reply_seq    = item.seq_number;
				if (len > cfg.max_file_size) begin
					res.reply_kind = RK_ERR;
					res.reply_code = EC_TOO_LARGE;
				end else begin
					receiving_d      = 1'b1;
					next_seq_d       = 32'd0;
					bytes_received_d = 32'd0;
					res.reply_kind   = RK_ACK;
					res.reply_code   = AC_START;
				end
			end
		end else if (same_peer) begin
			res.reply_tag = active_tag_q;
			res.reply_seq = item.seq_number;
			case (item.packet_kind)
				PK_START: begin
					res.reply_kind = RK_ACK;
					res.reply_code = AC_START;
				end
				PK_DATA: begin
					if (dup) begin
						res.reply_kind = RK_ACK;
						res.reply_code = AC_DATA;
					end else if (seq_fault) begin
						receiving_d    = 1'b0;
						res.reply_kind = RK_ERR;
						res.reply_code = EC_SEQUENCE;
						res.outcome    = OC_ABORTED;
					end else if (item.payload_check != item.header_check) begin
						receiving_d    = 1'b0;
						res.reply_kind = RK_ERR;
						res.reply_code = EC_CHECKSUM;
						res.outcome    = OC_ABORTED;
					end else begin
						res.reply_kind   = RK_ACK;
						res.reply_code   = AC_DATA;
						res.store_chunk  = 1'b1;
						res.store_offset = bytes_received_q;
						bytes_received_d = bytes_received_q + len;
						next_seq_d       = next_seq_q + 32'd1;
					end
				end
				PK_END: begin
					receiving_d = 1'b0;
					if (end_fault) begin
						res.reply_kind = RK_ERR;
						res.reply_code = EC_CHECKSUM;
						res.outcome    = OC_ABORTED;
					end else begin
						res.reply_kind = RK_ACK;
						res.reply_code = AC_END;
						res.outcome    = OC_COMPLETE;
					end
				end
				PK_ERROR: begin
					receiving_d = 1'b0;
					res         = '0;
					res.outcome = OC_ABORTED;
				end
				default: begin
					receiving_d    = 1'b0;
					res.reply_kind = RK_ERR;
					res.reply_code = EC_MALFORMED;
					res.outcome    = OC_ABORTED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q      <= 1'b0;
			peer_address_q   <= '0;
			active_tag_q     <= '0;
			expected_size_q  <= '0;
			expected_check_q <= '0;
			next_seq_q       <= '0;
			bytes_received_q <= '0;
		end else if (fire) begin
			receiving_q      <= receiving_d;
			peer_address_q   <= peer_address_d;
			active_tag_q     <= active_tag_d;
			expected_size_q  <= expected_size_d;
			expected_check_q <= expected_check_d;
			next_seq_q       <= next_seq_d;
			bytes_received_q <= bytes_received_d;
		end
	end

	a_store_is_data_ack: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.store_chunk |-> res.reply_kind == RK_ACK && res.reply_code == AC_DATA)
		else $error("store request without data ack");

	a_end_drops_receiving: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.outcome != OC_CONTINUE |=> !receiving_q)
		else $error("still receiving after complete or abort");

	a_idle_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !receiving_q && item.packet_kind != PK_START |->
		res.reply_kind == RK_NONE && res.outcome == OC_CONTINUE)
		else $error("idle receiver answered a non-start header");

	a_bytes_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.store_chunk |=>
		bytes_received_q == $past(bytes_received_q + item.length_field))
		else $error("byte count did not advance by chunk length");

endmodule

[hw/rtl/chunked_transfer_receiver.sv]
// ----------------------------------------------------------------------------
// chunked_transfer_receiver
// Receive side of a stop-and-wait chunked file transfer, one decoded header
// per transfer.
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall / item) carries one decoded header
//   with its payload checks; result channel (result_valid / result_stall /
//   result) returns exactly one reply per header, in order
//   headers pass an input register, then the decision logic and transfer
//   state, then an output register: result_valid rises when the reply is
//   loaded into the output register; throughput is one header per cycle
//   while result_stall does not hold the output register
//   the state update for a header happens when it moves into the output
//   register, so the next header always sees it
//   when result_stall is high the output holds its reply and one more header
//   waits in the input register; item_stall rises only when both are full
//   the apb port holds max_file_size (0x0) and max_chunk_len (0x4); write it
//   only while no header is in flight
//   reset clears both registers' valid flags, sets the receiver to waiting
//   for start and loads the limits with their defaults
// ----------------------------------------------------------------------------
module chunked_transfer_receiver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ctr_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output ctr_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ctr_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t core_res;
	logic    advance;
	logic    accept;

	ctr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
